// ----- rtl/core/egcd_pkg.sv -----
`default_nettype none

package egcd_pkg;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_START = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  // sequencer to division unit
  typedef struct packed {
    logic start;
  } step_ctl_t;

  // division unit to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } step_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/egcd_step.sv -----
`default_nettype none

module egcd_step #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire egcd_pkg::step_ctl_t    ctl,
  output egcd_pkg::step_stat_t        stat,
  input  wire logic [DATA_WIDTH-2:0]  dividend,
  input  wire logic [DATA_WIDTH-2:0]  divisor,
  input  wire logic [DATA_WIDTH-1:0]  s_in,
  input  wire logic [DATA_WIDTH-1:0]  t_in,
  output logic      [DATA_WIDTH-2:0]  rem,
  output logic      [DATA_WIDTH-1:0]  qs,
  output logic      [DATA_WIDTH-1:0]  qt
);
  import egcd_pkg::*;

  localparam int MW = DATA_WIDTH - 1;
  localparam int CW = $clog2(MW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] rem_r, quo_r, dsr_r;
  logic [DATA_WIDTH-1:0] s_r, t_r, qs_r, qt_r;

  logic [MW:0]   trial;
  logic [MW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit per cycle, msb first;
  // q*s and q*t build up by shift-and-add from the same quotient bit
  always_comb begin
    trial = {rem_r, quo_r[MW-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = ~diff[MW];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (ctl.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(MW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
      s_r   <= s_in;
      t_r   <= t_in;
      qs_r  <= '0;
      qt_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[MW-1:0] : trial[MW-1:0];
      quo_r <= {quo_r[MW-2:0], 1'b0};
      qs_r  <= {qs_r[DATA_WIDTH-2:0], 1'b0} + (ge ? s_r : '0);
      qt_r  <= {qt_r[DATA_WIDTH-2:0], 1'b0} + (ge ? t_r : '0);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;
  assign qs        = qs_r;
  assign qt        = qt_r;

  // a finished division has released the unit
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("step done while still dividing");

  // the remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dsr_r))
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ----- rtl/core/extended_gcd.sv -----
`default_nettype none

// extended euclidean gcd
//
// command channel: present in_operand_a and in_operand_b with start high; the
// transfer happens at the rising edge where start is high and busy is low.
// both operands are reduced to magnitudes (the most negative code saturates
// to the largest positive one). the result transfer is a single-cycle
// out_valid strobe carrying out_divisor (gcd) and out_coef_a / out_coef_b,
// with out_coef_a*|a| + out_coef_b*|b| == out_divisor. the receiver cannot
// stall, so out_valid marks each result for exactly one cycle.
// if either magnitude is zero the result appears in the cycle after the
// transfer. otherwise each euclid step runs through an issue state, the
// restoring division of the shared divider and a hand-back, and the
// result follows the step whose remainder is zero. the divider produces
// one quotient bit per cycle. busy stays high for the whole item unless a
// magnitude is zero, so one item is in work at a time.
// reset: synchronous active-low rst_n returns the sequencer to idle and
// drops out_valid; nothing is kept between items.
module extended_gcd #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  wire logic signed [DATA_WIDTH-1:0] in_operand_b,
  output logic                              out_valid,
  output logic             [DATA_WIDTH-2:0] out_divisor,
  output logic signed      [DATA_WIDTH-1:0] out_coef_a,
  output logic signed      [DATA_WIDTH-1:0] out_coef_b
);
  import egcd_pkg::*;

  localparam int MW = DATA_WIDTH - 1;
  localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // remainder pair and coefficient pairs of the running back-substitution:
  // r = s*large + t*small for both prev and cur
  logic [MW-1:0]          rp_r, rc_r;
  logic [DATA_WIDTH-1:0]  sp_r, sc_r, tp_r, tc_r;
  logic                   a_small_r;

  logic [MW-1:0]          out_divisor_r;
  logic [DATA_WIDTH-1:0]  out_coef_a_r, out_coef_b_r;

  logic                   accept;
  logic [DATA_WIDTH-1:0]  neg_a, neg_b;
  logic [MW-1:0]          mag_a, mag_b;
  logic                   a_small;
  logic [MW-1:0]          small_v, large_v;

  step_ctl_t              step_ctl;
  step_stat_t             step_stat;
  logic [MW-1:0]          step_rem;
  logic [DATA_WIDTH-1:0]  step_qs, step_qt;

  assign accept = start && !busy;

  // magnitudes, most negative code saturates
  always_comb begin
    neg_a = -in_operand_a;
    neg_b = -in_operand_b;
    if (!in_operand_a[DATA_WIDTH-1]) begin
      mag_a = in_operand_a[MW-1:0];
    end else if (neg_a[DATA_WIDTH-1]) begin
      mag_a = '1;
    end else begin
      mag_a = neg_a[MW-1:0];
    end
    if (!in_operand_b[DATA_WIDTH-1]) begin
      mag_b = in_operand_b[MW-1:0];
    end else if (neg_b[DATA_WIDTH-1]) begin
      mag_b = '1;
    end else begin
      mag_b = neg_b[MW-1:0];
    end
    // on a tie operand a counts as the smaller one
    a_small = (mag_a <= mag_b);
    small_v = a_small ? mag_a : mag_b;
    large_v = a_small ? mag_b : mag_a;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    step_ctl.start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (small_v == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        step_ctl.start = 1'b1;
        state_nxt      = S_WAIT;
      end
      S_WAIT: begin
        if (step_stat.done) begin
          if (step_rem == '0) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers and result registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      a_small_r <= a_small;
      rp_r      <= large_v;
      rc_r      <= small_v;
      sp_r      <= ONE;
      sc_r      <= '0;
      tp_r      <= '0;
      tc_r      <= ONE;
      // zero magnitude: the other one is the gcd with coefficient one
      out_divisor_r <= large_v;
      out_coef_a_r  <= a_small ? '0 : ONE;
      out_coef_b_r  <= a_small ? ONE : '0;
    end else if (state_r == S_WAIT && step_stat.done) begin
      if (step_rem == '0) begin
        out_divisor_r <= rc_r;
        out_coef_a_r  <= a_small_r ? tc_r : sc_r;
        out_coef_b_r  <= a_small_r ? sc_r : tc_r;
      end else begin
        rp_r <= rc_r;
        rc_r <= step_rem;
        sp_r <= sc_r;
        sc_r <= sp_r - step_qs;
        tp_r <= tc_r;
        tc_r <= tp_r - step_qt;
      end
    end
  end

  // shared divider: rp / rc, plus q*sc and q*tc
  egcd_step #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (step_ctl),
    .stat     (step_stat),
    .dividend (rp_r),
    .divisor  (rc_r),
    .s_in     (sc_r),
    .t_in     (tc_r),
    .rem      (step_rem),
    .qs       (step_qs),
    .qt       (step_qt)
  );

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_divisor = out_divisor_r;
  assign out_coef_a  = out_coef_a_r;
  assign out_coef_b  = out_coef_b_r;

  // an accepted command either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted command neither busy nor finished");

  // a result strobe leaves the block ready for the next command
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // divider hands back only while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step_stat.done |-> (state_r == S_WAIT))
    else $error("divider done outside wait state");

  // while waiting the divider is either running or handing back
  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> (step_stat.busy || step_stat.done))
    else $error("sequencer waits on an idle divider");

endmodule

`default_nettype wire
